// ===== rtl/core/esgt_pkg.sv =====
// Package for the edge stream graph tracker core.
// Holds node count constants, widths and the cell control struct; no dependencies.
package esgt_pkg;
    localparam int NODES   = 64;
    localparam int NODE_W  = $clog2(NODES);
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int TRI_W   = 11;
    localparam int DEG_W   = 6;
    localparam int SIZE_W  = 7;

    typedef struct packed {
        logic              clr_w;
        logic              tri_en;
        logic              tri_first;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
    } t_cell_ctl;
endpackage

// ===== rtl/core/esgt_cell.sv =====
// One node cell of the tracker: adjacency row, degrees, triangles.
// Depends on esgt_pkg. Cells pass the common-neighbor count down the chain.
module esgt_cell import esgt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NODE_W-1:0]   i_id,
    input  t_cell_ctl           i_ctl,
    input  logic                i_set_row,
    input  logic [NODE_W-1:0]   i_row_col,
    input  logic                i_inc_out,
    input  logic                i_inc_in,
    input  logic [TRI_W-1:0]    i_tri_add,
    input  logic                i_nb_u,
    input  logic                i_nb_v,
    input  logic [CNT_W-1:0]    i_cnt,
    output logic [CNT_W-1:0]    o_cnt,
    output logic [NODES-1:0]    o_row,
    output logic [DEG_W-1:0]    o_out_deg,
    output logic [DEG_W-1:0]    o_in_deg,
    output logic [TRI_W-1:0]    o_tri
);
    logic [NODES-1:0] r_row;
    logic [DEG_W-1:0] r_out, r_in;
    logic [TRI_W-1:0] r_tri, n_tri;
    logic             hit;

    assign hit = i_ctl.tri_en && i_nb_u && i_nb_v && i_id != i_ctl.u && i_id != i_ctl.v;

    always_comb begin
        n_tri = r_tri + i_tri_add;
        if (hit && i_ctl.tri_first) begin
            n_tri = n_tri + TRI_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_out <= '0;
            r_in  <= '0;
            r_tri <= '0;
            o_cnt <= '0;
        end else begin
            if (i_set_row) begin
                r_row[i_row_col] <= 1'b1;
            end
            if (i_inc_out) begin
                r_out <= r_out + DEG_W'(1);
            end
            if (i_inc_in) begin
                r_in <= r_in + DEG_W'(1);
            end
            r_tri <= n_tri;
            o_cnt <= i_ctl.clr_w ? '0 : i_cnt + CNT_W'(hit);
        end
    end

    assign o_row     = r_row;
    assign o_out_deg = r_out;
    assign o_in_deg  = r_in;
    assign o_tri     = r_tri;
endmodule

// ===== rtl/core/edge_stream_graph_tracker_core.sv =====
// An accepted insertion updates the rows, finds both roots, joins the sets, walks the
// 64-cell chain for triangles and then finds the roots again for the result; a query or a
// rejected insertion only finds the roots. Each union-find step reads, then follows, a parent.
// Throughput: one word at a time; busy falls in the cycle of the result strobe.
// Reset: synchronous active-low; the union-find tables are cleared entry by entry, busy
// meanwhile. The receiver cannot stall. Depends on esgt_pkg and esgt_cell.
module edge_stream_graph_tracker_core import esgt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_func,
    input  logic [5:0]          i_node_u,
    input  logic [5:0]          i_node_v,
    output logic                o_valid,
    output logic                o_accepted,
    output logic                o_edge_present,
    output logic                o_same_set,
    output logic [5:0]          o_u_out_degree,
    output logic [5:0]          o_u_in_degree,
    output logic [6:0]          o_u_set_size,
    output logic [10:0]         o_u_triangles,
    output logic [11:0]         o_total_edges,
    output logic [6:0]          o_total_nodes,
    output logic [6:0]          o_total_sets,
    output logic [15:0]         o_total_triangles,
    output logic [5:0]          o_largest_degree
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_UPD   = 4'd2;
    localparam logic [3:0] S_FU    = 4'd3;
    localparam logic [3:0] S_FV    = 4'd4;
    localparam logic [3:0] S_JOIN  = 4'd5;
    localparam logic [3:0] S_TRI   = 4'd6;
    localparam logic [3:0] S_TADD  = 4'd7;
    localparam logic [3:0] S_QU    = 4'd8;
    localparam logic [3:0] S_QV    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]        r_st;
    logic              r_dir, r_acc, r_fresh, r_phase;
    logic [NODE_W-1:0] r_u, r_v, r_a, r_ru, r_rv, r_cnt;
    logic [NODE_W:0]   r_steps;
    logic [NODES-1:0]  r_touch;
    logic [11:0]       r_edges;
    logic [6:0]        r_nodes, r_sets;
    logic [15:0]       r_tris;
    logic [5:0]        r_maxd;
    logic [NODE_W-1:0] parent_mem [NODES];
    logic [SIZE_W-1:0] size_mem [NODES];
    logic [NODE_W-1:0] r_par;
    logic [SIZE_W-1:0] r_szu, r_szv;

    t_cell_ctl         ctl;
    logic [CNT_W-1:0]  chain [NODES+1];
    logic [NODES-1:0]  rows [NODES];
    logic [DEG_W-1:0]  outd [NODES];
    logic [DEG_W-1:0]  ind [NODES];
    logic [TRI_W-1:0]  node_tri [NODES];
    logic [NODES-1:0]  col_u, col_v;
    logic [CNT_W-1:0]  tri_cnt;

    logic upd, dup, ins_ok;
    assign upd = r_st == S_UPD && !dup;
    assign dup = r_dir ? rows[r_u][r_v] : (rows[r_u][r_v] || rows[r_v][r_u]);

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            col_u[i] = rows[i][r_u] | rows[r_u][i];
            col_v[i] = rows[i][r_v] | rows[r_v][i];
        end
    end

    assign ctl.clr_w     = r_st != S_TRI;
    assign ctl.tri_en    = r_st == S_TRI && r_fresh;
    assign ctl.tri_first = r_st == S_TRI && r_cnt == '0;
    assign ctl.u         = r_u;
    assign ctl.v         = r_v;
    assign chain[0]      = '0;

    genvar g;
    generate
        for (g = 0; g < NODES; g++) begin : g_cell
            esgt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_id      (NODE_W'(g)),
                .i_ctl     (ctl),
                .i_set_row (upd && (NODE_W'(g) == r_u || (!r_dir && NODE_W'(g) == r_v))),
                .i_row_col (NODE_W'(g) == r_u ? r_v : r_u),
                .i_inc_out (upd && (NODE_W'(g) == r_u || (!r_dir && NODE_W'(g) == r_v))),
                .i_inc_in  (upd && r_dir && NODE_W'(g) == r_v),
                .i_tri_add ((r_st == S_TADD && (NODE_W'(g) == r_u || NODE_W'(g) == r_v))
                            ? TRI_W'(tri_cnt) : '0),
                .i_nb_u    (col_u[g]),
                .i_nb_v    (col_v[g]),
                .i_cnt     (chain[g]),
                .o_cnt     (chain[g+1]),
                .o_row     (rows[g]),
                .o_out_deg (outd[g]),
                .o_in_deg  (ind[g]),
                .o_tri     (node_tri[g])
            );
        end
    endgenerate
    assign tri_cnt = chain[NODES];

    always_ff @(posedge i_clk) begin
        r_par <= parent_mem[r_a];
        r_szu <= size_mem[r_ru];
        r_szv <= size_mem[r_rv];
    end

    logic [6:0]  n_tnodes;
    logic        t_u, t_v;
    assign t_u = !r_touch[r_u];
    assign t_v = !r_touch[r_v];
    assign n_tnodes = 7'(t_u) + 7'(t_v);
    assign ins_ok = !i_func && i_node_u != i_node_v;

    logic walk_done;
    assign walk_done = r_par == r_a || r_steps == (NODE_W+1)'(NODES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_a     <= '0;
            r_dir   <= 1'b0;
            r_phase <= 1'b0;
            r_touch <= '0;
            r_edges <= '0;
            r_nodes <= '0;
            r_sets  <= '0;
            r_tris  <= '0;
            r_maxd  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
            case (r_st)
                S_CLR: begin
                    parent_mem[r_a] <= r_a;
                    size_mem[r_a]   <= SIZE_W'(1);
                    r_a <= r_a + NODE_W'(1);
                    if (r_a == NODE_W'(NODES - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_u <= i_node_u;
                        r_v <= i_node_v;
                        r_acc <= 1'b0;
                        r_st <= S_QU;
                        if (ins_ok) begin
                            r_st <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (dup) begin
                        r_st <= S_QU;
                    end else begin
                        r_acc <= 1'b1;
                        r_touch[r_u] <= 1'b1;
                        r_touch[r_v] <= 1'b1;
                        r_nodes <= r_nodes + n_tnodes;
                        r_sets  <= r_sets + n_tnodes;
                        r_edges <= r_edges + 12'd1;
                        r_fresh <= r_dir ? !rows[r_v][r_u] : 1'b1;
                        if (outd[r_u] + DEG_W'(1) > r_maxd) begin
                            r_maxd <= outd[r_u] + DEG_W'(1);
                        end
                        if (!r_dir && outd[r_v] + DEG_W'(1) > r_maxd
                            && outd[r_v] >= outd[r_u]) begin
                            r_maxd <= outd[r_v] + DEG_W'(1);
                        end
                        r_a <= r_u;
                        r_steps <= '0;
                        r_st <= S_FU;
                    end
                end
                S_FU, S_FV, S_QU, S_QV: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (walk_done) begin
                            if (r_st == S_FU || r_st == S_QU) begin
                                r_ru <= r_a;
                                r_a <= r_v;
                                r_st <= (r_st == S_FU) ? S_FV : S_QV;
                            end else begin
                                r_rv <= r_a;
                                r_st <= (r_st == S_FV) ? S_JOIN : S_OUT;
                            end
                            r_steps <= '0;
                        end else begin
                            r_a <= r_par;
                            r_steps <= r_steps + (NODE_W+1)'(1);
                        end
                    end
                end
                S_JOIN: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_ru != r_rv) begin
                            r_sets <= r_sets - 7'd1;
                            if (r_szu < r_szv) begin
                                parent_mem[r_ru] <= r_rv;
                                size_mem[r_rv] <= r_szu + r_szv;
                            end else begin
                                parent_mem[r_rv] <= r_ru;
                                size_mem[r_ru] <= r_szu + r_szv;
                            end
                        end
                        r_cnt <= '0;
                        r_st <= S_TRI;
                    end
                end
                S_TRI: begin
                    r_cnt <= r_cnt + NODE_W'(1);
                    if (r_cnt == NODE_W'(NODES - 1)) begin
                        r_st <= S_TADD;
                    end
                end
                S_TADD: begin
                    if (r_fresh) begin
                        r_tris <= r_tris + 16'(tri_cnt);
                    end
                    r_a <= r_u;
                    r_steps <= '0;
                    r_st <= S_QU;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_accepted <= r_acc;
                    o_edge_present <= (r_u != r_v) && dup;
                    o_same_set <= r_touch[r_u] && r_touch[r_v] && r_ru == r_rv;
                    o_u_out_degree <= outd[r_u];
                    o_u_in_degree <= r_dir ? ind[r_u] : outd[r_u];
                    o_u_set_size <= r_touch[r_u] ? r_szu : '0;
                    o_u_triangles <= node_tri[r_u];
                    o_total_edges <= r_edges;
                    o_total_nodes <= r_nodes;
                    o_total_sets <= r_sets;
                    o_total_triangles <= r_tris;
                    o_largest_degree <= r_maxd;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_IDLE && start) begin
                r_a <= i_node_u;
                r_steps <= '0;
            end
        end
    end

    assign busy = r_st != S_IDLE;

`ifndef SYNTHESIS
    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy after result");
    a_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_UPD && !dup) |=> r_edges == $past(r_edges) + 12'd1)
        else $error("edge count slip");
`endif
endmodule
